[rtl/hsvrgb_pkg.sv]
package hsvrgb_pkg;

  // Stage count from the accepting edge to the edge at which a result is taken
  localparam int PIPE_DEPTH = 7;

  // Hue sectors of sixty degrees each
  localparam logic [2:0] SECTOR_RED_YEL  = 3'd0;
  localparam logic [2:0] SECTOR_YEL_GRN  = 3'd1;
  localparam logic [2:0] SECTOR_GRN_CYAN = 3'd2;
  localparam logic [2:0] SECTOR_CYAN_BLU = 3'd3;
  localparam logic [2:0] SECTOR_BLU_MAG  = 3'd4;
  localparam logic [2:0] SECTOR_MAG_RED  = 3'd5;

  typedef struct packed {
    logic [15:0] hue;
    logic [7:0]  saturation;
    logic [7:0]  value_pct;
    logic [31:0] duration;
  } item_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [6:0]  luma_pct;
    logic [31:0] duration_out;
  } result_t;

  // Sector and ramp position, handed from the hue path to the channel path
  typedef struct packed {
    logic [2:0] sector;
    logic [5:0] k;
  } hue_info_t;

endpackage

[rtl/hsvrgb_hue.sv]
module hsvrgb_hue import hsvrgb_pkg::*; (
  input  logic       clk,
  input  logic [15:0] hue,
  output hue_info_t  info
);

  // floor(2^24 / 360); the quotient comes out exact or one low
  localparam logic [15:0] HUE_RECIP = 16'd46603;

  logic [31:0] q_prod;
  logic [15:0] hue1;
  logic [7:0]  q1;
  logic [16:0] rem;
  logic [9:0]  rem_lo;
  logic [8:0]  h_next;
  logic [8:0]  h2;
  logic [8:0]  hm;
  logic [5:0]  k_next;
  logic [2:0]  sector_next;

  // Stage 1: estimate hue / 360
  assign q_prod = 32'(hue) * 32'(HUE_RECIP);

  always_ff @(posedge clk) begin
    hue1 <= hue;
    q1   <= q_prod[31:24];
  end

  // Stage 2: remainder, with one correction step
  assign rem    = 17'(hue1) - 17'(q1) * 17'd360;
  assign rem_lo = rem[9:0];
  assign h_next = (rem_lo >= 10'd360) ? 9'(rem_lo - 10'd360) : rem_lo[8:0];

  always_ff @(posedge clk) begin
    h2 <= h_next;
  end

  // Stage 3: sector and distance from the nearest primary
  always_comb begin
    if (h2 < 9'd60)       sector_next = SECTOR_RED_YEL;
    else if (h2 < 9'd120) sector_next = SECTOR_YEL_GRN;
    else if (h2 < 9'd180) sector_next = SECTOR_GRN_CYAN;
    else if (h2 < 9'd240) sector_next = SECTOR_CYAN_BLU;
    else if (h2 < 9'd300) sector_next = SECTOR_BLU_MAG;
    else                  sector_next = SECTOR_MAG_RED;
  end

  assign hm = (h2 >= 9'd240) ? (h2 - 9'd240) :
              (h2 >= 9'd120) ? (h2 - 9'd120) : h2;
  assign k_next = (hm >= 9'd60) ? 6'(9'd120 - hm) : hm[5:0];

  always_ff @(posedge clk) begin
    info.sector <= sector_next;
    info.k      <= k_next;
  end

endmodule

[rtl/hsvrgb_chan.sv]
module hsvrgb_chan import hsvrgb_pkg::*; (
  input  logic       clk,
  input  logic [7:0] saturation,
  input  logic [7:0] value_pct,
  input  hue_info_t  info,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue
);

  // ceil(2^26 / 375); exact quotient for numerators below 2^17
  localparam logic [17:0] CHAN_RECIP = 18'd178957;
  localparam logic [20:0] HALF_STEP  = 21'd3000;

  // Divide a prescaled numerator (already shifted right by four) by 375
  function automatic logic [7:0] div375(input logic [16:0] y);
    logic [34:0] prod;
    prod = 35'(y) * 35'(CHAN_RECIP);
    return prod[33:26];
  endfunction

  logic [6:0]  v1;
  logic [7:0]  s1;
  logic [6:0]  v2;
  logic [14:0] vs2;
  logic [14:0] vns2;
  logic [20:0] topn3;
  logic [20:0] botn3;
  logic [14:0] vs3;
  logic [20:0] midn;
  logic [16:0] top_y4;
  logic [16:0] bot_y4;
  logic [16:0] mid_y4;
  logic [2:0]  sector4;
  logic [7:0]  top_q;
  logic [7:0]  bot_q;
  logic [7:0]  mid_q;

  // Stage 1: clamp brightness
  always_ff @(posedge clk) begin
    v1 <= (value_pct > 8'd100) ? 7'd100 : value_pct[6:0];
    s1 <= saturation;
  end

  // Stage 2: v * s and v * (255 - s)
  always_ff @(posedge clk) begin
    v2   <= v1;
    vs2  <= 15'(v1) * 15'(s1);
    vns2 <= 15'(v1) * 15'(8'd255 - s1);
  end

  // Stage 3: top and bottom numerators over 6000, top already rounded
  always_ff @(posedge clk) begin
    topn3 <= 21'(v2) * 21'd15300 + HALF_STEP;
    botn3 <= 21'(vns2) * 21'd60;
    vs3   <= vs2;
  end

  // Stage 4: middle numerator, add the rounding half, drop four bits of 6000
  assign midn = botn3 + 21'(vs3) * 21'(info.k) + HALF_STEP;

  always_ff @(posedge clk) begin
    top_y4  <= topn3[20:4];
    bot_y4  <= 17'((botn3 + HALF_STEP) >> 4);
    mid_y4  <= midn[20:4];
    sector4 <= info.sector;
  end

  // Stage 5: finish the division and route to channels by sector
  assign top_q = div375(top_y4);
  assign bot_q = div375(bot_y4);
  assign mid_q = div375(mid_y4);

  always_ff @(posedge clk) begin
    unique case (sector4)
      SECTOR_RED_YEL: begin
        red <= top_q; green <= mid_q; blue <= bot_q;
      end
      SECTOR_YEL_GRN: begin
        red <= mid_q; green <= top_q; blue <= bot_q;
      end
      SECTOR_GRN_CYAN: begin
        red <= bot_q; green <= top_q; blue <= mid_q;
      end
      SECTOR_CYAN_BLU: begin
        red <= bot_q; green <= mid_q; blue <= top_q;
      end
      SECTOR_BLU_MAG: begin
        red <= mid_q; green <= bot_q; blue <= top_q;
      end
      default: begin
        red <= top_q; green <= bot_q; blue <= mid_q;
      end
    endcase
  end

endmodule

[rtl/hsvrgb_luma.sv]
module hsvrgb_luma import hsvrgb_pkg::*; (
  input  logic       clk,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output logic [7:0] red_out,
  output logic [7:0] green_out,
  output logic [7:0] blue_out,
  output logic [6:0] luma_pct
);

  // ceil(2^28 / 1275); exact quotient for values below 2^17
  localparam logic [17:0] LUMA_RECIP = 18'd210538;

  logic [17:0] w6;
  logic [7:0]  red6;
  logic [7:0]  green6;
  logic [7:0]  blue6;
  logic [17:0] z;
  logic [34:0] luma_prod;

  // Stage 6: weighted sum 299r + 587g + 114b
  always_ff @(posedge clk) begin
    w6     <= 18'(red) * 18'd299 + 18'(green) * 18'd587 + 18'(blue) * 18'd114;
    red6   <= red;
    green6 <= green;
    blue6  <= blue;
  end

  // Stage 7: (w + 1275) / 2550, split into a halving and a divide by 1275
  assign z         = w6 + 18'd1275;
  assign luma_prod = 35'(z[17:1]) * 35'(LUMA_RECIP);

  always_ff @(posedge clk) begin
    luma_pct  <= luma_prod[34:28];
    red_out   <= red6;
    green_out <= green6;
    blue_out  <= blue6;
  end

endmodule

[rtl/hsv_to_rgb_with_luma_core.sv]
// HSV to RGB converter with luma percent.
//
// Input channel: drive item (hue, saturation, value_pct, duration) and raise
// start; a transaction is taken at each rising edge where start is high and
// busy is low. busy is high only while rst is high, so one transaction can
// be taken every clock.
// Result channel: done is high for one cycle with result (red, green, blue,
// luma_pct, duration_out); the result is taken at the edge ending that cycle.
// The receiver cannot stall the block and need not: the pipeline never holds.
// Throughput: one transaction per cycle, set by the seven-stage pipeline
// (hue remainder, sector, products, reciprocal divides, luma sum, luma
// divide) with every multiplier fully pipelined.
// Reset clears the valid bits, so no result comes out for anything in
// flight when rst rises; data registers are not reset.
module hsv_to_rgb_with_luma_core import hsvrgb_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    done,
  output result_t result
);

  logic                  accept;
  logic [PIPE_DEPTH-1:0] valid;
  logic [31:0]           dur_pipe [PIPE_DEPTH];
  hue_info_t             info;
  logic [7:0]            red5;
  logic [7:0]            green5;
  logic [7:0]            blue5;
  logic [7:0]            red7;
  logic [7:0]            green7;
  logic [7:0]            blue7;
  logic [6:0]            luma7;

  assign busy   = rst;
  assign accept = start && !busy;

  // Advance the valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[PIPE_DEPTH-2:0], accept};
    end
  end

  // Carry the duration alongside the colour math
  always_ff @(posedge clk) begin
    dur_pipe[0] <= item.duration;
    for (int i = 1; i < PIPE_DEPTH; i++) begin
      dur_pipe[i] <= dur_pipe[i-1];
    end
  end

  hsvrgb_hue u_hue (
    .clk  (clk),
    .hue  (item.hue),
    .info (info)
  );

  hsvrgb_chan u_chan (
    .clk        (clk),
    .saturation (item.saturation),
    .value_pct  (item.value_pct),
    .info       (info),
    .red        (red5),
    .green      (green5),
    .blue       (blue5)
  );

  hsvrgb_luma u_luma (
    .clk       (clk),
    .red       (red5),
    .green     (green5),
    .blue      (blue5),
    .red_out   (red7),
    .green_out (green7),
    .blue_out  (blue7),
    .luma_pct  (luma7)
  );

  assign done                = valid[PIPE_DEPTH-1];
  assign result.red          = red7;
  assign result.green        = green7;
  assign result.blue         = blue7;
  assign result.luma_pct     = luma7;
  assign result.duration_out = dur_pipe[PIPE_DEPTH-1];

endmodule

[rtl/hsvrgb_checker.sv]
module hsvrgb_checker import hsvrgb_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input item_t   item,
  input logic    done,
  input result_t result
);

  // Every accepted transaction yields a result after the fixed latency
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_DEPTH done)
    else $error("accepted transaction produced no result");

  // No result appears without a matching transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##PIPE_DEPTH !done)
    else $error("result without an accepted transaction");

  // Duration comes out as it went in
  a_duration: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_DEPTH
      (result.duration_out == $past(item.duration, PIPE_DEPTH)))
    else $error("duration corrupted in flight");

  // Luma percent never exceeds one hundred
  a_luma_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.luma_pct <= 7'd100))
    else $error("luma percent out of range");

endmodule

bind hsv_to_rgb_with_luma_core hsvrgb_checker u_hsvrgb_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .done   (done),
  .result (result)
);

[dv/rgb_luma_checker.sv]
`timescale 1ns / 1ps

module rgb_luma_checker import hsvrgb_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    busy,
  input  item_t   item,
  input  logic    done,
  input  result_t result,
  output int      pending,
  output int      errors
);

  result_t     expected_rgb_q[$];
  int unsigned mismatch_cnt = 0;

  // Convert one HSV transaction to RGB plus luma, exact integer rounding
  function automatic result_t convert_hsv(item_t px);
    int unsigned h, s, v, hm, k, top, bot, mid, luma;
    logic [2:0]  sector;
    result_t     rgb;
    h = px.hue % 360;
    s = px.saturation;
    v = (px.value_pct > 8'd100) ? 100 : px.value_pct;
    // k ramps 0..60..0 across each pair of sectors
    hm = h % 120;
    k  = (hm >= 60) ? (120 - hm) : hm;
    top = (v * 255 * 60 + 3000) / 6000;
    bot = (v * (255 - s) * 60 + 3000) / 6000;
    mid = (v * (255 - s) * 60 + v * s * k + 3000) / 6000;
    sector = 3'(h / 60);
    case (sector)
      SECTOR_RED_YEL: begin
        rgb.red = 8'(top); rgb.green = 8'(mid); rgb.blue = 8'(bot);
      end
      SECTOR_YEL_GRN: begin
        rgb.red = 8'(mid); rgb.green = 8'(top); rgb.blue = 8'(bot);
      end
      SECTOR_GRN_CYAN: begin
        rgb.red = 8'(bot); rgb.green = 8'(top); rgb.blue = 8'(mid);
      end
      SECTOR_CYAN_BLU: begin
        rgb.red = 8'(bot); rgb.green = 8'(mid); rgb.blue = 8'(top);
      end
      SECTOR_BLU_MAG: begin
        rgb.red = 8'(mid); rgb.green = 8'(bot); rgb.blue = 8'(top);
      end
      default: begin
        rgb.red = 8'(top); rgb.green = 8'(bot); rgb.blue = 8'(mid);
      end
    endcase
    luma = (100 * (299 * rgb.red + 587 * rgb.green + 114 * rgb.blue) + 127500) / 255000;
    rgb.luma_pct     = 7'(luma);
    rgb.duration_out = px.duration;
    return rgb;
  endfunction

  // Compare one field and log it on mismatch
  task automatic check_field(input string field, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      mismatch_cnt++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
    end
  endtask

  // Predict on every accepted transaction, check every strobed result
  always @(posedge clk) begin : watch
    result_t want;
    if (!rst) begin
      if (done) begin
        if (expected_rgb_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected result, expected none, got 0x%0h", $time, result);
        end else begin
          want = expected_rgb_q.pop_front();
          check_field("red", want.red, result.red);
          check_field("green", want.green, result.green);
          check_field("blue", want.blue, result.blue);
          check_field("luma_pct", want.luma_pct, result.luma_pct);
          check_field("duration_out", want.duration_out, result.duration_out);
        end
      end
      if (start && !busy)
        expected_rgb_q.insert(expected_rgb_q.size(), convert_hsv(item));
    end
    pending <= expected_rgb_q.size();
    errors  <= mismatch_cnt;
  end

endmodule

[dv/tb_hsv_to_rgb_with_luma_core.sv]
`timescale 1ns / 1ps

module tb_hsv_to_rgb_with_luma_core;
  import hsvrgb_pkg::*;

  localparam int RANDOM_ITEMS = 500;
  localparam int CYCLE_LIMIT  = 20000;

  logic    clk = 1'b0;
  logic    rst;
  logic    start;
  logic    busy;
  item_t   item;
  logic    done;
  result_t result;
  int      pending;
  int      fail_cnt;
  int      cycle_cnt = 0;

  always #10 clk = ~clk;

  hsv_to_rgb_with_luma_core DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  rgb_luma_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .item    (item),
    .done    (done),
    .result  (result),
    .pending (pending),
    .errors  (fail_cnt)
  );

  // Stop a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic item_t make_pixel(input int unsigned h, input int unsigned s,
                                       input int unsigned v, input int unsigned dur);
    item_t px;
    px.hue        = 16'(h);
    px.saturation = 8'(s);
    px.value_pct  = 8'(v);
    px.duration   = dur;
    return px;
  endfunction

  // Present one transaction after an optional idle gap, hold until accepted
  task automatic send_pixel(input item_t px, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= px;
    do @(posedge clk); while (busy);
  endtask

  initial begin : stimulus
    item_t px;
    int    burst_left;
    rst   = 1'b1;
    start = 1'b0;
    item  = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Sector edges, saturation and brightness extremes, hue wrap, clamp, ties
    send_pixel(make_pixel(0, 255, 100, 0), 1'b0);
    send_pixel(make_pixel(59, 255, 100, 32'hFFFF_FFFF), 1'b0);
    send_pixel(make_pixel(60, 255, 100, 1), 1'b0);
    send_pixel(make_pixel(119, 255, 100, 2), 1'b1);
    send_pixel(make_pixel(120, 255, 100, 3), 1'b1);
    send_pixel(make_pixel(180, 255, 100, 4), 1'b1);
    send_pixel(make_pixel(240, 255, 100, 5), 1'b0);
    send_pixel(make_pixel(300, 255, 100, 6), 1'b0);
    send_pixel(make_pixel(359, 255, 100, 7), 1'b0);
    send_pixel(make_pixel(30, 128, 100, 32'h8000_0000), 1'b0);
    send_pixel(make_pixel(90, 200, 50, 32'h5A5A_5A5A), 1'b1);
    send_pixel(make_pixel(150, 1, 100, 32'hA5A5_A5A5), 1'b1);
    send_pixel(make_pixel(210, 255, 101, 8), 1'b0);
    send_pixel(make_pixel(270, 128, 255, 9), 1'b0);
    send_pixel(make_pixel(330, 0, 100, 10), 1'b0);
    send_pixel(make_pixel(360, 255, 100, 11), 1'b0);
    send_pixel(make_pixel(719, 255, 100, 12), 1'b1);
    send_pixel(make_pixel(65535, 255, 100, 13), 1'b1);
    send_pixel(make_pixel(45, 255, 0, 14), 1'b0);
    send_pixel(make_pixel(45, 0, 0, 15), 1'b0);
    send_pixel(make_pixel(100, 77, 10, 16), 1'b0);
    send_pixel(make_pixel(200, 0, 10, 17), 1'b0);
    send_pixel(make_pixel(65535, 255, 255, 32'hFFFF_FFFF), 1'b0);
    send_pixel(make_pixel(0, 0, 101, 0), 1'b1);

    // Random colors, alternating idle stretches with back-to-back bursts
    burst_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (burst_left == 0 && $urandom_range(0, 7) == 0)
        burst_left = $urandom_range(8, 30);
      px.hue        = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 359));
      px.saturation = 8'($urandom);
      px.value_pct  = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(101, 255))
                                                  : 8'($urandom_range(0, 100));
      px.duration   = $urandom;
      send_pixel(px, burst_left > 0);
      if (burst_left > 0)
        burst_left--;
    end
    start <= 1'b0;

    // Drain the pipeline, then watch for strays
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);

    if (fail_cnt == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
